// ===== rtl/core/per_source_connection_limiter_macros.svh =====
// Assertion macros shared by the connection limiter RTL.
`ifndef PER_SOURCE_CONNECTION_LIMITER_MACROS_SVH
`define PER_SOURCE_CONNECTION_LIMITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSCL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pscl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pscl assertion failed");

`endif

// ===== rtl/core/pscl_pkg.sv =====
// Shared types, constants and helpers for the per-source connection limiter.
`default_nettype none

package pscl_pkg;

	localparam int ADDR_W   = 64;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;
	localparam int REG_IDX_W = 3;

	// register indexes (byte address = 4 * index)
	localparam logic [REG_IDX_W-1:0] REG_LIMIT_EN  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_PER   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_V4_PREFIX = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_V6_PREFIX = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ACTIVE    = 3'd4;

	// register reset values
	localparam logic [5:0] V4_PREFIX_RST = 6'd32;
	localparam logic [7:0] V6_PREFIX_RST = 8'd64;
	localparam logic [6:0] ACTIVE_RST    = 7'd64;

	// input op codes
	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_DONE  = 1'b1;

	typedef struct packed {
		logic       limit_enabled;
		logic [6:0] max_per_source;
		logic [5:0] ipv4_prefix_len;
		logic [7:0] ipv6_prefix_len;
		logic [6:0] active_slots;
	} cfg_t;

	typedef struct packed {
		logic clearing;
		logic scanning;
	} status_t;

	// mask keeping the top n bits of a 64-bit word
	function automatic logic [ADDR_W-1:0] top_mask(input logic [7:0] n);
		logic [ADDR_W-1:0] m;
		if (n >= 8'd64) begin
			m = '1;
		end else begin
			m = ~({ADDR_W{1'b1}} >> n[5:0]);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pscl_cfg.sv =====
// Configuration register file with APB-style write and read access.
`default_nettype none

module pscl_cfg import pscl_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[PADDR_W-1:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit_enabled   <= 1'b0;
			cfg_q.max_per_source  <= 7'd0;
			cfg_q.ipv4_prefix_len <= V4_PREFIX_RST;
			cfg_q.ipv6_prefix_len <= V6_PREFIX_RST;
			cfg_q.active_slots    <= ACTIVE_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_LIMIT_EN:  cfg_q.limit_enabled   <= pwdata[0];
				REG_MAX_PER:   cfg_q.max_per_source  <= pwdata[6:0];
				REG_V4_PREFIX: cfg_q.ipv4_prefix_len <= pwdata[5:0];
				REG_V6_PREFIX: cfg_q.ipv6_prefix_len <= pwdata[7:0];
				REG_ACTIVE:    cfg_q.active_slots    <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LIMIT_EN:  prdata = {{(PDATA_W-1){1'b0}}, cfg_q.limit_enabled};
			REG_MAX_PER:   prdata = {{(PDATA_W-7){1'b0}}, cfg_q.max_per_source};
			REG_V4_PREFIX: prdata = {{(PDATA_W-6){1'b0}}, cfg_q.ipv4_prefix_len};
			REG_V6_PREFIX: prdata = {{(PDATA_W-8){1'b0}}, cfg_q.ipv6_prefix_len};
			REG_ACTIVE:    prdata = {{(PDATA_W-7){1'b0}}, cfg_q.active_slots};
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/pscl_table.sv =====
// Slot table memory: one write port, one read port, registered read data.
`default_nettype none

module pscl_table #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 138,
	parameter int IDX_W  = 6
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [IDX_W-1:0]  waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [IDX_W-1:0]  raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pscl_engine.sv =====
// Sequencer: clears the table after reset, scans it for each enforced item and writes back.
`default_nettype none

module pscl_engine import pscl_pkg::*; #(
	parameter int MAX_SLOTS = 64,
	parameter int ID_BITS   = 8,
	parameter int IDX_W     = 6,
	parameter int DATA_W    = 138
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	// input channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              op,
	input  wire logic [ID_BITS-1:0] conn_id,
	input  wire logic              addr_known,
	input  wire logic              is_ipv6,
	input  wire logic [ADDR_W-1:0] addr_hi,
	input  wire logic [ADDR_W-1:0] addr_lo,
	// output channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   allowed,
	output logic [6:0]             source_count,
	// table access
	output logic                   mem_we,
	output logic [IDX_W-1:0]       mem_waddr,
	output logic [DATA_W-1:0]      mem_wdata,
	output logic                   mem_re,
	output logic [IDX_W-1:0]       mem_raddr,
	input  wire logic [DATA_W-1:0] mem_rdata,
	output status_t                status
);

	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int N_W   = (CNT_W > 7) ? CNT_W : 7;

	// entry layout: {valid, id, is_v6, addr_hi, addr_lo}
	localparam int LO_B  = 0;
	localparam int HI_B  = ADDR_W;
	localparam int V6_B  = 2 * ADDR_W;
	localparam int ID_B  = V6_B + 1;
	localparam int VLD_B = ID_B + ID_BITS;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_CHECK = 2'd1;
	localparam logic [1:0] MODE_DONE  = 2'd2;

	logic [2:0]         state_q;
	logic [1:0]         mode_q;
	logic [1:0]         next_mode;
	logic [N_W-1:0]     ptr_q;
	logic [N_W-1:0]     count_q;
	logic [N_W-1:0]     used_n;
	logic [N_W-1:0]     active_ext;
	logic               sel_found_q;
	logic [IDX_W-1:0]   sel_idx_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               out_valid_q;
	logic               allowed_q;
	logic [6:0]         count_out_q;

	logic [ID_BITS-1:0] id_q;
	logic               v6_q;
	logic [ADDR_W-1:0]  hi_q;
	logic [ADDR_W-1:0]  lo_q;

	logic [ADDR_W-1:0]  m6_hi;
	logic [ADDR_W-1:0]  m6_lo;
	logic [ADDR_W-1:0]  m4;
	logic [ADDR_W-1:0]  masked_hi;
	logic [ADDR_W-1:0]  masked_lo;

	logic               accept;
	logic               clearing;
	logic               out_free;
	logic               fits;
	logic               commit;
	logic               finish_go;

	logic               e_valid;
	logic [ID_BITS-1:0] e_id;
	logic               e_v6;
	logic [ADDR_W-1:0]  e_hi;
	logic [ADDR_W-1:0]  e_lo;
	logic               src_match;
	logic               id_match;
	logic               take_sel;
	logic               bump;
	logic [6:0]         count_sat;

	assign active_ext = N_W'(cfg.active_slots);
	assign used_n     = (active_ext > N_W'(MAX_SLOTS)) ? N_W'(MAX_SLOTS) : active_ext;

	assign clearing  = (state_q == ST_CLEAR);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign finish_go = (state_q == ST_FINISH) && out_free;

	// prefix masking at accept
	assign m6_hi = top_mask(cfg.ipv6_prefix_len);
	assign m6_lo = (cfg.ipv6_prefix_len > 8'd64) ? top_mask(cfg.ipv6_prefix_len - 8'd64) : '0;
	assign m4    = top_mask({2'b00, cfg.ipv4_prefix_len});

	always_comb begin
		if (is_ipv6) begin
			masked_hi = addr_hi & m6_hi;
			masked_lo = addr_lo & m6_lo;
		end else begin
			masked_hi = '0;
			masked_lo = {32'b0, addr_lo[31:0] & m4[63:32]};
		end
	end

	always_comb begin
		if (!cfg.limit_enabled) begin
			next_mode = MODE_NONE;
		end else if (op == OP_DONE) begin
			next_mode = MODE_DONE;
		end else if (!addr_known) begin
			next_mode = MODE_NONE;
		end else if (is_ipv6 ? (cfg.ipv6_prefix_len > 8'd128)
		                     : (cfg.ipv4_prefix_len > 6'd32)) begin
			next_mode = MODE_NONE;
		end else begin
			next_mode = MODE_CHECK;
		end
	end

	// compare of the entry coming back from the table
	assign e_valid   = mem_rdata[VLD_B];
	assign e_id      = mem_rdata[VLD_B-1:ID_B];
	assign e_v6      = mem_rdata[V6_B];
	assign e_hi      = mem_rdata[V6_B-1:HI_B];
	assign e_lo      = mem_rdata[HI_B-1:LO_B];
	assign src_match = e_valid && (e_v6 == v6_q) && (e_hi == hi_q) && (e_lo == lo_q);
	assign id_match  = e_valid && (e_id == id_q);

	always_comb begin
		take_sel = 1'b0;
		bump     = 1'b0;
		if (rd_vld_s1 && !sel_found_q) begin
			if (mode_q == MODE_CHECK) begin
				take_sel = !e_valid;
			end else if (mode_q == MODE_DONE) begin
				take_sel = id_match;
			end
		end
		if (rd_vld_s1 && (mode_q == MODE_CHECK)) begin
			bump = src_match;
		end
	end

	assign fits      = count_q < N_W'(cfg.max_per_source);
	assign commit    = sel_found_q && ((mode_q == MODE_DONE) || ((mode_q == MODE_CHECK) && fits));
	assign count_sat = (count_q > N_W'(127)) ? 7'h7F : count_q[6:0];

	// table ports
	assign mem_re    = (state_q == ST_SCAN);
	assign mem_raddr = ptr_q[IDX_W-1:0];
	assign mem_we    = clearing || (finish_go && commit);
	assign mem_waddr = clearing ? ptr_q[IDX_W-1:0] : sel_idx_q;
	assign mem_wdata = (clearing || (mode_q == MODE_DONE)) ? '0 : {1'b1, id_q, v6_q, hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			mode_q      <= MODE_NONE;
			ptr_q       <= '0;
			count_q     <= '0;
			sel_found_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (take_sel) begin
				sel_found_q <= 1'b1;
			end
			if (bump) begin
				count_q <= count_q + N_W'(1);
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (ptr_q == N_W'(MAX_SLOTS - 1)) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + N_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						mode_q      <= next_mode;
						ptr_q       <= '0;
						count_q     <= '0;
						sel_found_q <= 1'b0;
						if ((next_mode != MODE_NONE) && (used_n != '0)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + N_W'(1);
					if (ptr_q + N_W'(1) == used_n) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q <= conn_id;
			v6_q <= is_ipv6;
			hi_q <= masked_hi;
			lo_q <= masked_lo;
		end
		if (state_q == ST_SCAN) begin
			rd_idx_s1 <= ptr_q[IDX_W-1:0];
		end
		if (take_sel) begin
			sel_idx_q <= rd_idx_s1;
		end
		if (finish_go) begin
			case (mode_q)
				MODE_CHECK: begin
					allowed_q   <= sel_found_q && fits;
					count_out_q <= count_sat;
				end
				default: begin
					allowed_q   <= 1'b1;
					count_out_q <= 7'd0;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign allowed      = allowed_q;
	assign source_count = count_out_q;

	assign status.clearing = clearing;
	assign status.scanning = (state_q == ST_SCAN) || (state_q == ST_DRAIN);

endmodule

`default_nettype wire

// ===== rtl/core/per_source_connection_limiter.sv =====
// Per-source connection limiter: top level with config port, sequencer and slot table.
//
// Usage notes:
// - Input channel (in_valid/in_stall) carries one item per transfer: op selects a
//   check-and-admit or a connection-done release. Output channel (out_valid/out_stall)
//   returns one result per item: allowed and source_count.
// - A check masks the peer address to the family's prefix length, then reads every
//   active slot once through the table's single read port, counting matching sources
//   and picking the lowest free slot; one write commits the new entry. A done item
//   runs the same scan looking for the id and frees the first hit.
// - A scanned item reads the active slots in turn, waits in a drain state for the last
//   read to return, then writes back and registers the result in the finish state; an
//   item settled without a scan goes straight to the finish state. One item is in flight
//   at a time, so a new item is taken only once the last one has finished.
// - Reset clears the control registers at once, then sweeps the table one slot a cycle
//   until every slot is clear; in_stall stays high during that sweep. Config writes are taken.
// - The result sits in an output register; a stalled receiver holds it there and the
//   block finishes the next item only once that register is free.
// - Config registers may be written only while the block is idle.
`default_nettype none

`include "per_source_connection_limiter_macros.svh"

module per_source_connection_limiter import pscl_pkg::*; #(
	parameter int MAX_SLOTS = 64,
	parameter int ID_BITS   = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// config port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               op,
	input  wire logic [ID_BITS-1:0] conn_id,
	input  wire logic               addr_known,
	input  wire logic               is_ipv6,
	input  wire logic [ADDR_W-1:0]  addr_hi,
	input  wire logic [ADDR_W-1:0]  addr_lo,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    allowed,
	output logic [6:0]              source_count
);

	// table geometry follows from the slot count and id width
	localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int DATA_W = 2 + ID_BITS + 2 * ADDR_W;

	cfg_t              cfg;
	status_t           status;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	pscl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: accept, scan, decide, write back, present the result
	pscl_engine #(
		.MAX_SLOTS (MAX_SLOTS),
		.ID_BITS   (ID_BITS),
		.IDX_W     (IDX_W),
		.DATA_W    (DATA_W)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.conn_id      (conn_id),
		.addr_known   (addr_known),
		.is_ipv6      (is_ipv6),
		.addr_hi      (addr_hi),
		.addr_lo      (addr_lo),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.allowed      (allowed),
		.source_count (source_count),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.status       (status)
	);

	// slot table: {valid, id, family, masked address} per slot
	pscl_table #(
		.DEPTH  (MAX_SLOTS),
		.DATA_W (DATA_W),
		.IDX_W  (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// an accepted item keeps the input closed for at least the next cycle
	`PSCL_ASSERT_NEXT(a_accept_closes, clk, arst_n, in_valid && !in_stall, in_stall)
	// a scan read never collides with a table write
	`PSCL_ASSERT_NOW(a_no_rw_clash, clk, arst_n, mem_re, !mem_we)
	// while the table sweep runs, nothing is taken and nothing is presented
	`PSCL_ASSERT_NOW(a_clear_quiet, clk, arst_n, status.clearing, in_stall && !out_valid)
	// a scan in progress keeps the input closed
	`PSCL_ASSERT_NOW(a_scan_stalls, clk, arst_n, status.scanning, in_stall)

endmodule

`default_nettype wire

// ===== tb/sv/pscl_admission_checker.sv =====
// Checker for the connection limiter: tracks the slot table, predicts each result, compares.
module pscl_admission_checker import pscl_pkg::*; #(
	parameter int SLOTS   = 64,
	parameter int ID_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               op,
	input  logic [ID_BITS-1:0] conn_id,
	input  logic               addr_known,
	input  logic               is_ipv6,
	input  logic [ADDR_W-1:0]  addr_hi,
	input  logic [ADDR_W-1:0]  addr_lo,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               allowed,
	input  logic [6:0]         source_count,
	output int                 mismatches,
	output int                 awaited
);

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic       allowed;
		logic [6:0] source_count;
	} admission_t;

	// register copies
	bit       lim_on;
	bit [6:0] per_source_max;
	bit [5:0] v4_len;
	bit [7:0] v6_len;
	bit [6:0] slots_cfg;

	// slot table copy
	bit                used [SLOTS];
	bit [ID_BITS-1:0]  slot_id [SLOTS];
	bit                slot_v6 [SLOTS];
	bit [ADDR_W-1:0]   slot_hi [SLOTS];
	bit [ADDR_W-1:0]   slot_lo [SLOTS];

	admission_t pending_admissions[$];
	admission_t want;
	int         results_seen;

	function automatic logic [ADDR_W-1:0] keep_top(input int unsigned n);
		if (n == 0)
			return '0;
		if (n >= ADDR_W)
			return '1;
		return {ADDR_W{1'b1}} << (ADDR_W - n);
	endfunction

	// one item against the table; updates the table copy as the block would
	function automatic admission_t admit_or_release(input logic op_i,
			input logic [ID_BITS-1:0] id_i, input logic known_i, input logic v6_i,
			input logic [ADDR_W-1:0] hi_i, input logic [ADDR_W-1:0] lo_i);
		admission_t        v;
		int unsigned       n, count, free_idx;
		logic [ADDR_W-1:0] hi, lo, m4;
		bit                released;
		v.allowed = 1'b1;
		v.source_count = '0;
		n = (slots_cfg > SLOTS) ? SLOTS : slots_cfg;
		hi = hi_i;
		lo = lo_i;
		released = 1'b0;
		count = 0;
		free_idx = n;
		if (!lim_on)
			return v;
		if (op_i == OP_DONE) begin
			for (int i = 0; i < n; i++) begin
				if (!released && used[i] && slot_id[i] == id_i) begin
					used[i] = 1'b0;
					released = 1'b1;
				end
			end
			return v;
		end
		if (!known_i)
			return v;
		if (v6_i) begin
			if (v6_len > 128)
				return v;
			hi = hi & keep_top(v6_len);
			lo = (v6_len > 64) ? (lo & keep_top(v6_len - 64)) : '0;
		end else begin
			if (v4_len > 32)
				return v;
			m4 = keep_top(v4_len);
			hi = '0;
			lo = {32'd0, lo[31:0] & m4[63:32]};
		end
		for (int i = 0; i < n; i++) begin
			if (!used[i]) begin
				if (free_idx == n)
					free_idx = i;
			end else if (slot_v6[i] == v6_i && slot_hi[i] == hi && slot_lo[i] == lo) begin
				count++;
			end
		end
		v.source_count = (count > 127) ? 7'd127 : count[6:0];
		if (free_idx >= n || count >= per_source_max) begin
			v.allowed = 1'b0;
			return v;
		end
		used[free_idx] = 1'b1;
		slot_id[free_idx] = id_i;
		slot_v6[free_idx] = v6_i;
		slot_hi[free_idx] = hi;
		slot_lo[free_idx] = lo;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_on = 1'b0;
			per_source_max = '0;
			v4_len = V4_PREFIX_RST;
			v6_len = V6_PREFIX_RST;
			slots_cfg = ACTIVE_RST;
			for (int i = 0; i < SLOTS; i++)
				used[i] = 1'b0;
			pending_admissions.delete();
			results_seen = 0;
			mismatches <= 0;
			awaited <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_LIMIT_EN:  lim_on = pwdata[0];
					REG_MAX_PER:   per_source_max = pwdata[6:0];
					REG_V4_PREFIX: v4_len = pwdata[5:0];
					REG_V6_PREFIX: v6_len = pwdata[7:0];
					REG_ACTIVE:    slots_cfg = pwdata[6:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pending_admissions.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: result %0d with nothing awaited: allowed=%0b count=%0d",
							$time, results_seen, allowed, source_count);
					mismatches <= mismatches + 1;
				end else begin
					want = pending_admissions.pop_front();
					if (allowed !== want.allowed || source_count !== want.source_count) begin
						if (mismatches < MAX_REPORTS)
							$display("%0t: result %0d wrong: expected allowed=%0b count=%0d, got allowed=%0b count=%0d",
								$time, results_seen, want.allowed, want.source_count,
								allowed, source_count);
						mismatches <= mismatches + 1;
					end
				end
				results_seen++;
			end
			if (in_valid && !in_stall)
				pending_admissions.push_back(admit_or_release(op, conn_id, addr_known, is_ipv6,
					addr_hi, addr_lo));
			awaited <= pending_admissions.size();
		end
	end

endmodule

// ===== tb/sv/per_source_connection_limiter_tb.sv =====
// Testbench top for the per-source connection limiter: stimulus, config writes, verdict.
module per_source_connection_limiter_tb;
	import pscl_pkg::*;

	localparam int PERIOD        = 8;
	localparam int RESET_CYCLES  = 6;
	localparam int ID_W          = 8;
	localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
	localparam int TAIL_CYCLES   = 140;    // a bit over twice the longest scan
	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS   = 105;
	localparam int SOURCES       = 4;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid, in_stall;
	logic               op;
	logic [ID_W-1:0]    conn_id;
	logic               addr_known, is_ipv6;
	logic [ADDR_W-1:0]  addr_hi, addr_lo;
	logic               out_valid, out_stall;
	logic               allowed;
	logic [6:0]         source_count;

	int mismatches;
	int awaited;

	// sender burst bookkeeping and the receiver hold-off request
	int  burst_left = 0;
	bit  hold_req = 1'b0;

	// ids handed out by checks in the current phase, used to build done transfers
	logic [ID_W-1:0]   live_ids[$];
	// per-phase pool of sources so that checks keep hitting the same masked prefix
	logic [ADDR_W-1:0] src_hi [SOURCES];
	logic [ADDR_W-1:0] src_lo [SOURCES];
	logic              src_v6 [SOURCES];

	always #(PERIOD / 2) clk = ~clk;

	per_source_connection_limiter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.conn_id      (conn_id),
		.addr_known   (addr_known),
		.is_ipv6      (is_ipv6),
		.addr_hi      (addr_hi),
		.addr_lo      (addr_lo),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.allowed      (allowed),
		.source_count (source_count)
	);

	pscl_admission_checker #(.SLOTS(64), .ID_BITS(ID_W)) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.conn_id      (conn_id),
		.addr_known   (addr_known),
		.is_ipv6      (is_ipv6),
		.addr_hi      (addr_hi),
		.addr_lo      (addr_lo),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.allowed      (allowed),
		.source_count (source_count),
		.mismatches   (mismatches),
		.awaited      (awaited)
	);

	function automatic logic [ADDR_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// low n bits set, n in 0..64
	function automatic logic [ADDR_W-1:0] low_mask(input int unsigned n);
		if (n >= ADDR_W)
			return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	// Offer one transfer and return once it is taken. A new burst starts with a
	// random gap (sometimes none), so idle cycles land on every phase of a scan.
	task automatic drive_item(input logic op_i, input logic [ID_W-1:0] id_i,
			input logic known_i, input logic v6_i,
			input logic [ADDR_W-1:0] hi_i, input logic [ADDR_W-1:0] lo_i);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		in_valid   <= 1'b1;
		op         <= op_i;
		conn_id    <= id_i;
		addr_known <= known_i;
		is_ipv6    <= v6_i;
		addr_hi    <= hi_i;
		addr_lo    <= lo_i;
		do @(posedge clk); while (in_stall);
		burst_left--;
	endtask

	// Sender goes quiet until every predicted result has been taken; the block is
	// idle afterwards since each transfer yields exactly one result.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (awaited != 0);
	endtask

	// APB write: setup, access (register written at that edge), then back to idle.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input bit en, input logic [6:0] max_per,
			input logic [5:0] v4, input logic [7:0] v6, input logic [6:0] act);
		write_reg(REG_LIMIT_EN, {31'd0, en});
		write_reg(REG_MAX_PER, {25'd0, max_per});
		write_reg(REG_V4_PREFIX, {26'd0, v4});
		write_reg(REG_V6_PREFIX, {24'd0, v6});
		write_reg(REG_ACTIVE, {25'd0, act});
	endtask

	// Receiver: stretches of random stall density, including stretches with none.
	// A hold-off request keeps it stalled for a long count while the sender keeps
	// offering, so the result register fills and the block stalls its input.
	initial begin
		int pct, len, n;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				case ($urandom_range(0, 4))
					0: pct = 0;
					1: pct = 20;
					2: pct = 50;
					3: pct = 85;
					default: pct = $urandom_range(0, 100);
				endcase
				len = $urandom_range(8, 160);
				n = 0;
				while (n < len && !hold_req) begin
					out_stall <= ($urandom_range(0, 99) < pct);
					@(posedge clk);
					n++;
				end
			end
		end
	end

	initial begin
		#(LIMIT_CYCLES * PERIOD);
		$display("per_source_connection_limiter: mismatch");
		$finish;
	end

	initial begin
		int                ph, k, s, r, sel, w;
		logic [ID_W-1:0]   id;
		logic [ADDR_W-1:0] hi, lo;
		bit                en_v;
		logic [6:0]        max_v, act_v;
		logic [5:0]        v4_v;
		logic [7:0]        v6_v;

		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		in_valid   <= 1'b0;
		op         <= OP_CHECK;
		conn_id    <= '0;
		addr_known <= 1'b0;
		is_ipv6    <= 1'b0;
		addr_hi    <= '0;
		addr_lo    <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// limiting off after reset: check and done both just pass
		drive_item(OP_CHECK, 8'h01, 1'b1, 1'b0, '0, 64'h0A01_0203);
		drive_item(OP_DONE, 8'h01, 1'b1, 1'b0, '0, '0);

		// /24 and /64 grouping, two per source, eight slots
		drain();
		set_config(1'b1, 7'd2, 6'd24, 8'd64, 7'd8);
		drive_item(OP_CHECK, 8'h00, 1'b1, 1'b0, '0, 64'h0A01_0203);
		drive_item(OP_CHECK, 8'hFF, 1'b1, 1'b0, '0, 64'h0A01_02C8);
		// source at its limit: refused
		drive_item(OP_CHECK, 8'h02, 1'b1, 1'b0, '0, 64'h0A01_0209);
		// upper address bits are ignored for IPv4, so same source and still refused
		drive_item(OP_CHECK, 8'h03, 1'b1, 1'b0, '1, 64'hFFFF_FFFF_0A01_02FE);
		drive_item(OP_CHECK, 8'h04, 1'b1, 1'b1, '1, '1);
		drive_item(OP_CHECK, 8'h05, 1'b1, 1'b1, '1, '0);
		// unknown peer address: always allowed, nothing stored
		drive_item(OP_CHECK, 8'h06, 1'b0, 1'b0, '0, 64'h0A01_0203);
		drive_item(OP_DONE, 8'h00, 1'b1, 1'b0, '0, '0);
		// done for an id that holds no slot
		drive_item(OP_DONE, 8'hAA, 1'b1, 1'b0, '0, '0);
		drive_item(OP_CHECK, 8'h07, 1'b1, 1'b0, '0, 64'h0A01_02FF);

		// prefixes beyond the family width: allowed without a scan
		drain();
		set_config(1'b1, 7'd127, 6'd40, 8'd200, 7'd8);
		drive_item(OP_CHECK, 8'h10, 1'b1, 1'b0, '0, 64'hC0A8_0001);
		drive_item(OP_CHECK, 8'h11, 1'b1, 1'b1, 64'h2001_0DB8_0000_0000, 64'h1);

		// zero-length prefixes, three slots: table runs out of room
		drain();
		set_config(1'b1, 7'd127, 6'd0, 8'd0, 7'd3);
		drive_item(OP_CHECK, 8'h20, 1'b1, 1'b0, '0, 64'h0102_0304);
		drive_item(OP_CHECK, 8'h21, 1'b1, 1'b1, '1, '1);
		drive_item(OP_CHECK, 8'h22, 1'b1, 1'b0, '0, 64'hFFFF_FFFF);

		// no slots at all: every enforced check refused
		drain();
		set_config(1'b1, 7'd127, 6'd32, 8'd128, 7'd0);
		drive_item(OP_CHECK, 8'h30, 1'b1, 1'b0, '0, 64'h0A00_0001);

		// zero per-source limit with slot count above the table size
		drain();
		set_config(1'b1, 7'd0, 6'd32, 8'd128, 7'd127);
		drive_item(OP_CHECK, 8'h31, 1'b1, 1'b1, 64'h2001_0DB8_0000_0001, 64'h2);

		// limiting off: done is ignored
		drain();
		set_config(1'b0, 7'd4, 6'd32, 8'd128, 7'd64);
		drive_item(OP_DONE, 8'hFF, 1'b1, 1'b0, '0, '0);

		// --- random phases ---
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			en_v = ($urandom_range(0, 9) != 0);
			case ($urandom_range(0, 5))
				0: max_v = 7'd0;
				1: max_v = 7'($urandom_range(1, 4));
				2: max_v = 7'd64;
				3: max_v = 7'd127;
				default: max_v = 7'($urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 4))
				0: v4_v = 6'd0;
				1: v4_v = 6'd32;
				2: v4_v = 6'($urandom_range(33, 63));
				default: v4_v = 6'($urandom_range(0, 32));
			endcase
			case ($urandom_range(0, 5))
				0: v6_v = 8'd0;
				1: v6_v = 8'd128;
				2: v6_v = 8'($urandom_range(129, 255));
				3: v6_v = 8'd64;
				default: v6_v = 8'($urandom_range(0, 128));
			endcase
			// mostly small tables keep the scans short
			case ($urandom_range(0, 9))
				0: act_v = 7'd0;
				1: act_v = 7'd64;
				2: act_v = 7'd127;
				3: act_v = 7'($urandom_range(65, 126));
				default: act_v = 7'($urandom_range(1, 16));
			endcase
			set_config(en_v, max_v, v4_v, v6_v, act_v);

			for (s = 0; s < SOURCES; s++) begin
				src_v6[s] = 1'($urandom_range(0, 1));
				src_hi[s] = rand64();
				src_lo[s] = rand64();
			end
			live_ids.delete();
			if (ph == 2 || ph == 7)
				hold_req = 1'b1;

			for (k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (r < 28 && live_ids.size() > 0) begin
					// release a connection admitted earlier (if it was)
					sel = $urandom_range(0, live_ids.size() - 1);
					id = live_ids[sel];
					live_ids.delete(sel);
					drive_item(OP_DONE, id, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), rand64(), rand64());
				end else if (r < 34) begin
					drive_item(OP_DONE, ID_W'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						rand64(), rand64());
				end else if (r < 39) begin
					drive_item(OP_CHECK, ID_W'($urandom_range(0, 255)), 1'b0,
						1'($urandom_range(0, 1)), rand64(), rand64());
				end else if (r < 47) begin
					// stray peer, almost surely a source of its own
					drive_item(OP_CHECK, ID_W'($urandom_range(0, 255)), 1'b1,
						1'($urandom_range(0, 1)), rand64(), rand64());
				end else begin
					// peer near a pooled source: low bits vary, often inside the prefix
					s = $urandom_range(0, SOURCES - 1);
					hi = src_hi[s];
					if ($urandom_range(0, 3) == 0)
						hi = hi ^ (rand64() & low_mask($urandom_range(0, 64)));
					w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 12);
					lo = src_lo[s] ^ (rand64() & low_mask(w));
					id = ID_W'($urandom_range(0, 255));
					live_ids.push_back(id);
					drive_item(OP_CHECK, id, 1'b1, src_v6[s], hi, lo);
				end
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited == 0) begin
			$display("per_source_connection_limiter: match");
		end else begin
			$display("per_source_connection_limiter: mismatch");
		end
		$finish;
	end

endmodule
